// ----- rtl/core/etcm_pkg.sv -----
// ----------------------------------------------------------------------------
// etcm_pkg
// Shared types, codes and constants of the eight-bit timer channel with two
// compare constants and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

package etcm_pkg;

   localparam int CYC_W   = 13;   // free-running cycle counter width
   localparam int NUM_DIV = 6;    // prescaler dividers, three low/high pairs
   localparam int SEL_W   = 3;    // divider select width

   localparam int DEF_DIV_SEL1_LOW  = 8;
   localparam int DEF_DIV_SEL1_HIGH = 8;
   localparam int DEF_DIV_SEL2_LOW  = 64;
   localparam int DEF_DIV_SEL2_HIGH = 64;
   localparam int DEF_DIV_SEL3_LOW  = 8192;
   localparam int DEF_DIV_SEL3_HIGH = 8192;

   // Item actions.
   localparam logic [2:0] ACT_TICK      = 3'd0;
   localparam logic [2:0] ACT_CHAIN_OV  = 3'd1;
   localparam logic [2:0] ACT_CHAIN_A   = 3'd2;
   localparam logic [2:0] ACT_WR_COUNT  = 3'd3;
   localparam logic [2:0] ACT_RD_COUNT  = 3'd4;
   localparam logic [2:0] ACT_WR_STATUS = 3'd5;
   localparam logic [2:0] ACT_RD_STATUS = 3'd6;

   // Clock select codes, control word bits 2:0.
   localparam logic [2:0] CKS_STOP  = 3'd0;
   localparam logic [2:0] CKS_DIV1  = 3'd1;
   localparam logic [2:0] CKS_DIV2  = 3'd2;
   localparam logic [2:0] CKS_DIV3  = 3'd3;
   localparam logic [2:0] CKS_CHAIN = 3'd4;

   // Clear mode codes, control word bits 4:3.
   localparam logic [1:0] CLR_NONE = 2'd0;
   localparam logic [1:0] CLR_A    = 2'd1;
   localparam logic [1:0] CLR_B    = 2'd2;

   // Chain source codes.
   localparam logic [1:0] CHAIN_STOP = 2'd0;
   localparam logic [1:0] CHAIN_CMPA = 2'd1;
   localparam logic [1:0] CHAIN_OVF  = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_CONTROL   = 3'd0;
   localparam logic [2:0] REG_COMPARE_A = 3'd1;
   localparam logic [2:0] REG_COMPARE_B = 3'd2;
   localparam logic [2:0] REG_EXTRA_CKS = 3'd3;
   localparam logic [2:0] REG_CHAIN_SRC = 3'd4;
   localparam logic [2:0] REG_EXT_STAT  = 3'd5;

   // Flag and enable bit positions in status and control bytes.
   localparam int FLAG_B_BIT  = 7;
   localparam int FLAG_A_BIT  = 6;
   localparam int FLAG_OV_BIT = 5;

   localparam logic [7:0] STATUS_MASK     = 8'h0f;
   localparam logic [7:0] STATUS_MASK_EXT = 8'h1f;
   localparam logic [7:0] STATUS_RESET    = 8'h10;
   localparam logic [7:0] COUNT_MAX       = 8'hff;

   typedef struct packed {
      logic [7:0] control_word;
      logic [7:0] compare_a;
      logic [7:0] compare_b;
      logic       extra_clock_select;
      logic [1:0] chain_source;
      logic       extended_status;
   } cfg_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_match_a;
      logic       irq_match_b;
      logic       irq_overflow;
      logic       chain_match_out;
      logic       chain_overflow_out;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/etcm_req_if.sv -----
// ----------------------------------------------------------------------------
// etcm_req_if
// Input channel: one tick, chain event or bus access per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface etcm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] write_data;

   modport source (output valid, output action, output write_data, input ready);
   modport sink   (input valid, input action, input write_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/etcm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// etcm_rsp_if
// Result channel: read data, interrupt pulses and chain events per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface etcm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       irq_match_a;
   logic       irq_match_b;
   logic       irq_overflow;
   logic       chain_match_out;
   logic       chain_overflow_out;

   modport source (output valid, output read_data, output irq_match_a,
                   output irq_match_b, output irq_overflow,
                   output chain_match_out, output chain_overflow_out,
                   input ready);
   modport sink   (input valid, input read_data, input irq_match_a,
                   input irq_match_b, input irq_overflow,
                   input chain_match_out, input chain_overflow_out,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/core/etcm_csr_if.sv -----
// ----------------------------------------------------------------------------
// etcm_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface etcm_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/etcm_prescaler.sv -----
// ----------------------------------------------------------------------------
// etcm_prescaler
// Free-running tick counter with one residue register per divider, so the
// phase test needs no divider.
// ----------------------------------------------------------------------------
`default_nettype none

module etcm_prescaler #(
   parameter int DIV_SEL1_LOW  = etcm_pkg::DEF_DIV_SEL1_LOW,
   parameter int DIV_SEL1_HIGH = etcm_pkg::DEF_DIV_SEL1_HIGH,
   parameter int DIV_SEL2_LOW  = etcm_pkg::DEF_DIV_SEL2_LOW,
   parameter int DIV_SEL2_HIGH = etcm_pkg::DEF_DIV_SEL2_HIGH,
   parameter int DIV_SEL3_LOW  = etcm_pkg::DEF_DIV_SEL3_LOW,
   parameter int DIV_SEL3_HIGH = etcm_pkg::DEF_DIV_SEL3_HIGH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       tick,
   input  wire logic [etcm_pkg::SEL_W-1:0] div_sel,
   output      logic                       phase_hit
);
   import etcm_pkg::*;

   localparam logic [CYC_W:0] DIV_TAB [NUM_DIV] = '{
      (CYC_W+1)'(DIV_SEL1_LOW), (CYC_W+1)'(DIV_SEL1_HIGH),
      (CYC_W+1)'(DIV_SEL2_LOW), (CYC_W+1)'(DIV_SEL2_HIGH),
      (CYC_W+1)'(DIV_SEL3_LOW), (CYC_W+1)'(DIV_SEL3_HIGH)
   };
   localparam logic [CYC_W-1:0] HALF_TAB [NUM_DIV] = '{
      CYC_W'(DIV_SEL1_LOW / 2), CYC_W'(DIV_SEL1_HIGH / 2),
      CYC_W'(DIV_SEL2_LOW / 2), CYC_W'(DIV_SEL2_HIGH / 2),
      CYC_W'(DIV_SEL3_LOW / 2), CYC_W'(DIV_SEL3_HIGH / 2)
   };

   logic [CYC_W-1:0] cyc_ff, cyc_in;
   logic [CYC_W-1:0] res_ff [NUM_DIV];
   logic [CYC_W-1:0] res_in [NUM_DIV];
   logic [CYC_W-1:0] res_sel, half_sel;

   // Each residue tracks the cycle counter modulo its divider; it restarts
   // at zero when the cycle counter itself wraps.
   always_comb begin
      cyc_in = cyc_ff;
      for (int k = 0; k < NUM_DIV; k++) begin
         res_in[k] = res_ff[k];
      end
      if (tick) begin
         cyc_in = cyc_ff + 1'b1;
         for (int k = 0; k < NUM_DIV; k++) begin
            if (cyc_ff == {CYC_W{1'b1}}) begin
               res_in[k] = '0;
            end else if (({1'b0, res_ff[k]} + 1'b1) == DIV_TAB[k]) begin
               res_in[k] = '0;
            end else begin
               res_in[k] = res_ff[k] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      res_sel  = '0;
      half_sel = '0;
      for (int k = 0; k < NUM_DIV; k++) begin
         if (div_sel == SEL_W'(k)) begin
            res_sel  = res_in[k];
            half_sel = HALF_TAB[k];
         end
      end
   end

   assign phase_hit = (res_sel == half_sel);

   always_ff @(posedge clock) begin
      if (reset) begin
         cyc_ff <= '0;
         for (int k = 0; k < NUM_DIV; k++) begin
            res_ff[k] <= '0;
         end
      end else begin
         cyc_ff <= cyc_in;
         for (int k = 0; k < NUM_DIV; k++) begin
            res_ff[k] <= res_in[k];
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/etcm_channel.sv -----
// ----------------------------------------------------------------------------
// etcm_channel
// Count and status registers with the step, compare, clear and bus logic
// for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module etcm_channel (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [2:0]        action,
   input  wire logic [7:0]        write_data,
   input  wire etcm_pkg::cfg_type cfg,
   input  wire logic              phase_hit,
   output      etcm_pkg::rsp_type result
);
   import etcm_pkg::*;

   logic [7:0] count_ff, count_in;
   logic [7:0] status_ff, status_in;
   logic [2:0] cks;
   logic [1:0] clr_mode;
   logic       step, wrap;
   logic       hit_a, hit_b, hit_ov;
   logic [7:0] wr_mask;

   assign cks      = cfg.control_word[2:0];
   assign clr_mode = cfg.control_word[4:3];
   assign wr_mask  = cfg.extended_status ? STATUS_MASK_EXT : STATUS_MASK;

   always_comb begin
      step = 1'b0;
      if (action == ACT_TICK) begin
         step = phase_hit && (cks == CKS_DIV1 || cks == CKS_DIV2 || cks == CKS_DIV3);
      end else if (action == ACT_CHAIN_OV) begin
         step = (cks == CKS_CHAIN) && (cfg.chain_source == CHAIN_OVF);
      end else if (action == ACT_CHAIN_A) begin
         step = (cks == CKS_CHAIN) && (cfg.chain_source == CHAIN_CMPA);
      end
   end

   assign hit_a  = (count_ff == cfg.compare_a);
   assign hit_b  = (count_ff == cfg.compare_b);
   assign hit_ov = (count_ff == COUNT_MAX);
   // Reaching compare+1 of the selected constant is the same as the old
   // count equaling that constant.
   assign wrap   = hit_ov || (clr_mode == CLR_A && hit_a) || (clr_mode == CLR_B && hit_b);

   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      result    = '0;
      if (step) begin
         count_in = wrap ? 8'h00 : count_ff + 1'b1;
         if (hit_a) begin
            result.chain_match_out = 1'b1;
            if (!status_ff[FLAG_A_BIT]) begin
               status_in[FLAG_A_BIT] = 1'b1;
               result.irq_match_a    = cfg.control_word[FLAG_A_BIT];
            end
         end
         if (hit_b && !status_ff[FLAG_B_BIT]) begin
            status_in[FLAG_B_BIT] = 1'b1;
            result.irq_match_b    = cfg.control_word[FLAG_B_BIT];
         end
         if (hit_ov) begin
            result.chain_overflow_out = 1'b1;
            if (!status_ff[FLAG_OV_BIT]) begin
               status_in[FLAG_OV_BIT] = 1'b1;
               result.irq_overflow    = cfg.control_word[FLAG_OV_BIT];
            end
         end
      end
      unique case (action)
         ACT_WR_COUNT: begin
            count_in = write_data;
         end
         ACT_RD_COUNT: begin
            result.read_data = count_ff;
         end
         ACT_WR_STATUS: begin
            // Flags in bits 7:5 can only be cleared by writing zero.
            status_in = ((status_ff & ~wr_mask) | (write_data & wr_mask))
                        & (write_data | STATUS_MASK_EXT);
         end
         ACT_RD_STATUS: begin
            result.read_data = status_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         status_ff <= STATUS_RESET;
      end else if (fire) begin
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/eight_bit_timer_compare_match.sv -----
// An accepted word waits in the input register until the result register
// is free or being read. Throughput: one word per cycle unless the
// result side stalls; the input and result registers let a new word in
// while a result waits, and the count update is a single pass.
// Reset clears the count, cycle counter and prescaler residues, sets the
// status byte to 0x10 and the registers to their reset values.
// ----------------------------------------------------------------------------
// eight_bit_timer_compare_match
// Eight-bit timer channel with dual compare match, overflow and chaining.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_timer_compare_match #(
   parameter int DIV_SEL1_LOW  = etcm_pkg::DEF_DIV_SEL1_LOW,
   parameter int DIV_SEL1_HIGH = etcm_pkg::DEF_DIV_SEL1_HIGH,
   parameter int DIV_SEL2_LOW  = etcm_pkg::DEF_DIV_SEL2_LOW,
   parameter int DIV_SEL2_HIGH = etcm_pkg::DEF_DIV_SEL2_HIGH,
   parameter int DIV_SEL3_LOW  = etcm_pkg::DEF_DIV_SEL3_LOW,
   parameter int DIV_SEL3_HIGH = etcm_pkg::DEF_DIV_SEL3_HIGH
) (
   input wire logic  clock,
   input wire logic  reset,
   etcm_req_if.sink   req_chan,
   etcm_rsp_if.source rsp_chan,
   etcm_csr_if.sink   csr_chan
);
   import etcm_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [2:0] act_ff;
   logic [7:0] data_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    result;
   logic       advance, tick, phase_hit;
   logic [SEL_W-1:0] div_sel;
   logic [1:0] cks_low;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign tick           = advance && (act_ff == ACT_TICK);

   // Divider index is (clock select - 1) * 2 + extra select.
   assign cks_low = cfg_ff.control_word[1:0] - 2'd1;
   assign div_sel = {cks_low, cfg_ff.extra_clock_select};

   etcm_prescaler #(
      .DIV_SEL1_LOW  (DIV_SEL1_LOW),
      .DIV_SEL1_HIGH (DIV_SEL1_HIGH),
      .DIV_SEL2_LOW  (DIV_SEL2_LOW),
      .DIV_SEL2_HIGH (DIV_SEL2_HIGH),
      .DIV_SEL3_LOW  (DIV_SEL3_LOW),
      .DIV_SEL3_HIGH (DIV_SEL3_HIGH)
   ) u_prescaler (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .div_sel   (div_sel),
      .phase_hit (phase_hit)
   );

   etcm_channel u_channel (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .action     (act_ff),
      .write_data (data_ff),
      .cfg        (cfg_ff),
      .phase_hit  (phase_hit),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_word       <= '0;
         cfg_ff.compare_a          <= COUNT_MAX;
         cfg_ff.compare_b          <= COUNT_MAX;
         cfg_ff.extra_clock_select <= 1'b0;
         cfg_ff.chain_source       <= CHAIN_STOP;
         cfg_ff.extended_status    <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_CONTROL:   cfg_ff.control_word       <= csr_chan.data;
            REG_COMPARE_A: cfg_ff.compare_a          <= csr_chan.data;
            REG_COMPARE_B: cfg_ff.compare_b          <= csr_chan.data;
            REG_EXTRA_CKS: cfg_ff.extra_clock_select <= csr_chan.data[0];
            REG_CHAIN_SRC: cfg_ff.chain_source       <= csr_chan.data[1:0];
            REG_EXT_STAT:  cfg_ff.extended_status    <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         act_ff  <= req_chan.action;
         data_ff <= req_chan.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.read_data          = rsp_ff.read_data;
   assign rsp_chan.irq_match_a        = rsp_ff.irq_match_a;
   assign rsp_chan.irq_match_b        = rsp_ff.irq_match_b;
   assign rsp_chan.irq_overflow       = rsp_ff.irq_overflow;
   assign rsp_chan.chain_match_out    = rsp_ff.chain_match_out;
   assign rsp_chan.chain_overflow_out = rsp_ff.chain_overflow_out;

   // A compare A interrupt always comes with the chain event of the same step.
   a_irq_a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.irq_match_a |-> rsp_ff.chain_match_out)
      else $error("compare A interrupt without chain event");

   a_irq_ov_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.irq_overflow |-> rsp_ff.chain_overflow_out)
      else $error("overflow interrupt without chain event");

   // Bus reads never step the count, so read data excludes any event.
   a_read_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.read_data != 8'h00
      |-> !rsp_ff.chain_match_out && !rsp_ff.chain_overflow_out
          && !rsp_ff.irq_match_b)
      else $error("read result carries a counter event");

   // A word held in the input register is not lost while the result stalls.
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(act_ff))
      else $error("stalled input word dropped");

endmodule

`default_nettype wire

// ----- bench/etcm_checker.sv -----
// ----------------------------------------------------------------------------
// etcm_checker
// Watches the request, result and register channels of the timer channel.
// It keeps its own copy of the count, status byte, tick counter and
// registers, works out the result word for every accepted request word and
// compares it field by field with the result words as they leave the block.
// ----------------------------------------------------------------------------
module etcm_checker (
   input  logic clock,
   input  logic reset,
   etcm_req_if  req_mon,
   etcm_rsp_if  rsp_mon,
   etcm_csr_if  csr_mon,
   output int   mismatch_count,
   output int   words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import etcm_pkg::*;

   cfg_type     cfg;
   logic [7:0]  count_now;
   logic [7:0]  status_now;
   logic [12:0] tick_count;
   rsp_type     expected_q[$];

   function automatic void apply_setting(input logic [2:0] idx, input logic [7:0] val);
      case (idx)
         REG_CONTROL:   cfg.control_word = val;
         REG_COMPARE_A: cfg.compare_a = val;
         REG_COMPARE_B: cfg.compare_b = val;
         REG_EXTRA_CKS: cfg.extra_clock_select = val[0];
         REG_CHAIN_SRC: cfg.chain_source = val[1:0];
         REG_EXT_STAT:  cfg.extended_status = val[0];
         default: ;
      endcase
   endfunction

   // One count step. Flags that are already set still give the chain
   // outputs, but no interrupt pulse.
   function automatic void count_step(inout rsp_type r);
      logic [7:0] prev;
      int         period;
      int         nxt;
      prev = count_now;
      case (cfg.control_word[4:3])
         CLR_A:   period = int'(cfg.compare_a) + 1;
         CLR_B:   period = int'(cfg.compare_b) + 1;
         default: period = 256;
      endcase
      nxt = int'(prev) + 1;
      if (nxt == period || prev == COUNT_MAX) nxt = 0;
      count_now = 8'(nxt);

      if (prev == cfg.compare_a) begin
         r.chain_match_out = 1'b1;
         if (!status_now[FLAG_A_BIT]) begin
            status_now[FLAG_A_BIT] = 1'b1;
            r.irq_match_a = cfg.control_word[FLAG_A_BIT];
         end
      end
      if (prev == cfg.compare_b && !status_now[FLAG_B_BIT]) begin
         status_now[FLAG_B_BIT] = 1'b1;
         r.irq_match_b = cfg.control_word[FLAG_B_BIT];
      end
      if (prev == COUNT_MAX) begin
         r.chain_overflow_out = 1'b1;
         if (!status_now[FLAG_OV_BIT]) begin
            status_now[FLAG_OV_BIT] = 1'b1;
            r.irq_overflow = cfg.control_word[FLAG_OV_BIT];
         end
      end
   endfunction

   function automatic rsp_type predict_word(input logic [2:0] act, input logic [7:0] wd);
      rsp_type    r;
      int         div;
      logic [7:0] keep;
      r = '0;
      case (act)
         ACT_TICK: begin
            tick_count = tick_count + 13'd1;
            case (cfg.control_word[2:0])
               CKS_DIV1: div = cfg.extra_clock_select ? DEF_DIV_SEL1_HIGH : DEF_DIV_SEL1_LOW;
               CKS_DIV2: div = cfg.extra_clock_select ? DEF_DIV_SEL2_HIGH : DEF_DIV_SEL2_LOW;
               CKS_DIV3: div = cfg.extra_clock_select ? DEF_DIV_SEL3_HIGH : DEF_DIV_SEL3_LOW;
               default:  div = 0;
            endcase
            if (div != 0 && int'(tick_count) % div == div / 2) count_step(r);
         end
         ACT_CHAIN_OV: begin
            if (cfg.control_word[2:0] == CKS_CHAIN && cfg.chain_source == CHAIN_OVF)
               count_step(r);
         end
         ACT_CHAIN_A: begin
            if (cfg.control_word[2:0] == CKS_CHAIN && cfg.chain_source == CHAIN_CMPA)
               count_step(r);
         end
         ACT_WR_COUNT:  count_now = wd;
         ACT_RD_COUNT:  r.read_data = count_now;
         ACT_WR_STATUS: begin
            // Low bits are plain storage; the flags can only be cleared.
            keep = cfg.extended_status ? STATUS_MASK_EXT : STATUS_MASK;
            status_now = (status_now & ~keep) | (wd & keep);
            status_now = status_now & (wd | STATUS_MASK_EXT);
         end
         ACT_RD_STATUS: r.read_data = status_now;
         default: ;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_result();
      rsp_type want;
      if (expected_q.size() == 0) begin
         $error("result word with no request word waiting for it");
         mismatch_count++;
         return;
      end
      want = expected_q.pop_front();
      check_field("read_data", want.read_data, rsp_mon.read_data);
      check_field("irq_match_a", 8'(want.irq_match_a), 8'(rsp_mon.irq_match_a));
      check_field("irq_match_b", 8'(want.irq_match_b), 8'(rsp_mon.irq_match_b));
      check_field("irq_overflow", 8'(want.irq_overflow), 8'(rsp_mon.irq_overflow));
      check_field("chain_match_out", 8'(want.chain_match_out),
                  8'(rsp_mon.chain_match_out));
      check_field("chain_overflow_out", 8'(want.chain_overflow_out),
                  8'(rsp_mon.chain_overflow_out));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.control_word       = '0;
         cfg.compare_a          = COUNT_MAX;
         cfg.compare_b          = COUNT_MAX;
         cfg.extra_clock_select = 1'b0;
         cfg.chain_source       = CHAIN_STOP;
         cfg.extended_status    = 1'b0;
         count_now              = '0;
         status_now             = STATUS_RESET;
         tick_count             = '0;
         expected_q.delete();
         mismatch_count         = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            apply_setting(csr_mon.index, csr_mon.data);
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(predict_word(req_mon.action, req_mon.write_data));
         if (rsp_mon.valid && rsp_mon.ready)
            check_result();
      end
      words_pending = expected_q.size();
   end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the eight-bit timer channel. A short directed run covers the
// bus accesses, chained stepping, overflow, compare matches and flag
// clearing; then random phases, each with fresh register settings, drive
// count preloads near the compare points followed by runs of clock events.
// Both channels see random gaps and stalls. The checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import etcm_pkg::*;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   words_pending;
   bit   no_gaps;
   int   words_sent;
   cfg_type cfg_now;

   etcm_req_if req_if ();
   etcm_rsp_if rsp_if ();
   etcm_csr_if csr_if ();

   eight_bit_timer_compare_match u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   etcm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_mon        (csr_if),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #5ns clock = ~clock;

   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic int gap_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Result side: short stalls now and then, a few long ones.
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && !no_gaps) begin
            r = $urandom_range(0, 99);
            if (r < 15) stall_left = $urandom_range(1, 3);
            else if (r < 18) stall_left = $urandom_range(8, 30);
         end
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic [2:0] act, input logic [7:0] wd);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.write_data <= wd;
      do @(posedge clock); while (!req_if.ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_CONTROL:   cfg_now.control_word = val;
         REG_COMPARE_A: cfg_now.compare_a = val;
         REG_COMPARE_B: cfg_now.compare_b = val;
         REG_EXTRA_CKS: cfg_now.extra_clock_select = val[0];
         REG_CHAIN_SRC: cfg_now.chain_source = val[1:0];
         REG_EXT_STAT:  cfg_now.extended_status = val[0];
         default: ;
      endcase
   endtask

   // Registers change only once every result word is out and the block has settled.
   task automatic drain_words();
      int guard;
      guard = 0;
      req_if.valid <= 1'b0;
      while (words_pending != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic pick_settings(input int ph);
      logic [2:0] cks;
      int         r;
      if (ph == 0) begin
         write_reg(REG_CONTROL, 8'hff);
         write_reg(REG_COMPARE_A, 8'hff);
         write_reg(REG_COMPARE_B, 8'hff);
         write_reg(REG_EXTRA_CKS, 8'h01);
         write_reg(REG_CHAIN_SRC, 8'h03);
         write_reg(REG_EXT_STAT, 8'h01);
      end else if (ph == 1) begin
         // Clear on B with B at zero: a step from zero keeps the count at zero.
         write_reg(REG_CONTROL, {3'b111, CLR_B, CKS_DIV1});
         write_reg(REG_COMPARE_A, 8'h00);
         write_reg(REG_COMPARE_B, 8'h00);
         write_reg(REG_EXTRA_CKS, 8'h00);
         write_reg(REG_CHAIN_SRC, {6'd0, CHAIN_STOP});
         write_reg(REG_EXT_STAT, 8'h00);
      end else begin
         r = $urandom_range(0, 9);
         if (r < 4) cks = CKS_CHAIN;
         else if (r < 7) cks = CKS_DIV1;
         else if (r == 7) cks = CKS_DIV2;
         else if (r == 8) cks = CKS_DIV3;
         else cks = 3'($urandom_range(0, 7));
         write_reg(REG_CONTROL, {3'($urandom), 2'($urandom), cks});
         r = $urandom_range(0, 9);
         write_reg(REG_COMPARE_A, r < 2 ? 8'h00 : r < 4 ? 8'hff : 8'($urandom));
         r = $urandom_range(0, 9);
         write_reg(REG_COMPARE_B, r < 2 ? 8'h00 : r < 4 ? 8'hff : 8'($urandom));
         write_reg(REG_EXTRA_CKS, 8'($urandom_range(0, 1)));
         if ($urandom_range(0, 9) < 8)
            write_reg(REG_CHAIN_SRC, 8'($urandom_range(1, 2)));
         else
            write_reg(REG_CHAIN_SRC, 8'($urandom_range(0, 3)));
         write_reg(REG_EXT_STAT, 8'($urandom_range(0, 1)));
      end
   endtask

   function automatic logic [2:0] step_action();
      if (cfg_now.control_word[2:0] != CKS_CHAIN) return ACT_TICK;
      if (cfg_now.chain_source == CHAIN_CMPA) return ACT_CHAIN_A;
      if (cfg_now.chain_source == CHAIN_OVF) return ACT_CHAIN_OV;
      return $urandom_range(0, 1) ? ACT_CHAIN_A : ACT_CHAIN_OV;
   endfunction

   initial begin
      logic [7:0] target;
      int         steps;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = ACT_TICK;
      req_if.write_data = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = REG_CONTROL;
      csr_if.data       = '0;
      no_gaps           = 1'b0;
      words_sent        = 0;
      cfg_now           = {8'h00, 8'hff, 8'hff, 1'b0, CHAIN_STOP, 1'b0};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Bus accesses with the clock stopped; chain events are ignored.
      send_word(ACT_RD_COUNT, 8'h00);
      send_word(ACT_RD_STATUS, 8'h00);
      send_word(ACT_WR_COUNT, 8'hff);
      send_word(ACT_RD_COUNT, 8'h00);
      send_word(ACT_WR_STATUS, 8'hff);
      send_word(ACT_RD_STATUS, 8'h00);
      send_word(ACT_WR_STATUS, 8'h00);
      send_word(ACT_RD_STATUS, 8'hff);
      send_word(ACT_TICK, 8'hff);
      send_word(ACT_CHAIN_OV, 8'h00);
      send_word(ACT_CHAIN_A, 8'h00);
      send_word(3'd7, 8'hff);
      drain_words();

      // Chained on overflow: wrap past 255 sets overflow and B, then A.
      write_reg(REG_CONTROL, {3'b111, CLR_NONE, CKS_CHAIN});
      write_reg(REG_COMPARE_A, 8'h00);
      write_reg(REG_CHAIN_SRC, {6'd0, CHAIN_OVF});
      send_word(ACT_WR_COUNT, 8'hfe);
      repeat (3) send_word(ACT_CHAIN_OV, 8'h00);
      send_word(ACT_CHAIN_A, 8'h00);
      send_word(ACT_WR_COUNT, 8'hff);
      send_word(ACT_CHAIN_OV, 8'h00);
      send_word(ACT_RD_STATUS, 8'h00);
      send_word(ACT_WR_STATUS, 8'h00);
      drain_words();

      // Clear on A, count preloaded above the clear period.
      write_reg(REG_CONTROL, {3'b111, CLR_A, CKS_CHAIN});
      write_reg(REG_COMPARE_A, 8'h05);
      write_reg(REG_CHAIN_SRC, {6'd0, CHAIN_CMPA});
      write_reg(REG_EXT_STAT, 8'h01);
      send_word(ACT_WR_COUNT, 8'hfd);
      repeat (3) send_word(ACT_CHAIN_A, 8'h00);
      send_word(ACT_WR_STATUS, 8'h00);
      send_word(ACT_RD_STATUS, 8'h00);
      drain_words();

      for (int ph = 0; ph < 12; ph++) begin
         pick_settings(ph);
         no_gaps = ($urandom_range(0, 3) == 0);
         words_sent = 0;
         while (words_sent < 108) begin
            if ($urandom_range(0, 9) < 7) begin
               case ($urandom_range(0, 3))
                  0:       target = cfg_now.compare_a;
                  1:       target = cfg_now.compare_b;
                  2:       target = COUNT_MAX;
                  default: target = 8'($urandom);
               endcase
               send_word(ACT_WR_COUNT, target - 8'($urandom_range(0, 3)));
               if (cfg_now.control_word[2:0] == CKS_DIV1)
                  steps = $urandom_range(8, 40);
               else
                  steps = $urandom_range(1, 10);
               repeat (steps) send_word(step_action(), 8'($urandom));
               if ($urandom_range(0, 1)) send_word(ACT_RD_COUNT, 8'($urandom));
               send_word(ACT_RD_STATUS, 8'($urandom));
               if ($urandom_range(0, 2) == 0) send_word(ACT_WR_STATUS, 8'($urandom));
            end else begin
               send_word(3'($urandom_range(0, 7)), 8'($urandom));
            end
         end
         no_gaps = 1'b0;
         drain_words();
      end

      if (mismatch_count == 0 && words_pending == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ----- eight_bit_timer_compare_match.f -----
rtl/core/etcm_pkg.sv
rtl/core/etcm_req_if.sv
rtl/core/etcm_rsp_if.sv
rtl/core/etcm_csr_if.sv
rtl/core/etcm_prescaler.sv
rtl/core/etcm_channel.sv
rtl/core/eight_bit_timer_compare_match.sv
bench/etcm_checker.sv
bench/testbench.sv
